@@ sv/falling_object_length_measure_macros.svh @@
// assertion macros for the falling object length measure block
// used by the top level only, expects clk and rst_n in scope
`ifndef FALLING_OBJECT_LENGTH_MEASURE_MACROS_SVH
`define FALLING_OBJECT_LENGTH_MEASURE_MACROS_SVH

// same-cycle implication
`define FLOM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLOM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/flom_pkg.sv @@
// shared types and constants of the falling object length measure block
// no dependencies
package flom_pkg;

    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int DELAY_W     = 16;
    localparam int RAD_W       = 2 * LEN_W;
    localparam int VQ_W        = 64;
    localparam int VQ_INT_POS  = 48;
    localparam int K1_BITS     = 45;
    localparam int K2_BITS     = 29;
    localparam int K3_BITS     = 29;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;

    // kinematic coefficients: n/d term in Q32, n*d term in Q48, n*n term in Q40
    localparam logic [63:0] K1_Q32 = (64'd42504 << 31) / 64'd5;
    localparam logic [63:0] K2_Q48 = (64'd13533177 << 35) / 64'd1220703125;
    localparam logic [63:0] K3_Q40 = (64'd3735156852 << 27) / 64'd1220703125;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DELAY = 2'd1,
        ST_ROW_ORDER  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RIGHT_EDGE_OFFSET = 1'b0,
        REG_LEFT_EDGE_OFFSET  = 1'b1
    } cfg_reg_t;

    // flags that ride along with the final root
    typedef struct packed {
        status_t status;
        logic    sat;
    } flom_flags_t;

endpackage

@@ sv/flom_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no dependencies
module flom_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 16,
    parameter int QUO_W = 48,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic [TAG_W-1:0] out_tag
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [QUO_W:0]   valid_reg;
    logic [DEN_W-1:0] rem_reg [0:QUO_W];
    logic [QUO_W-1:0] qd_reg  [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic [TAG_W-1:0] tag_reg [0:QUO_W];

    logic [HI_W-1:0] hi;
    logic            ovf_next;

    // quotient overflows when the bits above it already reach the divisor
    assign hi       = num[NUM_W-1:QUO_W];
    assign ovf_next = CMP_W'(hi) >= CMP_W'(den);

    // valid bits move with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(hi);
            qd_reg[0]  <= num[QUO_W-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= in_tag;
        end
    end

    // one shift-subtract step per stage, quotient bits enter at the bottom
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        logic [DEN_W:0] part;
        logic [DEN_W:0] diff;
        logic           ge;

        assign part = {rem_reg[i], qd_reg[i][QUO_W-1]};
        assign diff = part - {1'b0, den_reg[i]};
        assign ge   = part >= {1'b0, den_reg[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
                qd_reg[i+1]  <= {qd_reg[i][QUO_W-2:0], ge};
                den_reg[i+1] <= den_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo       = qd_reg[QUO_W];
    assign ovf       = ovf_reg[QUO_W];
    assign out_tag   = tag_reg[QUO_W];

endmodule

@@ sv/flom_isqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on flom_pkg
module flom_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [flom_pkg::RAD_W-1:0] rad,
    input  logic [TAG_W-1:0]           in_tag,
    output logic                       out_valid,
    output logic [flom_pkg::LEN_W-1:0] root,
    output logic [TAG_W-1:0]           out_tag
);

    import flom_pkg::*;

    localparam int REM_W = LEN_W + 2;

    logic [LEN_W:0]   valid_reg;
    logic [RAD_W-1:0] x_reg    [0:LEN_W];
    logic [REM_W-1:0] rem_reg  [0:LEN_W];
    logic [LEN_W-1:0] root_reg [0:LEN_W];
    logic [TAG_W-1:0] tag_reg  [0:LEN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LEN_W-1:0], in_valid};
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    // two radicand bits per stage, trial subtract of 4*root+1
    for (genvar i = 0; i < LEN_W; i++)
    begin : g_step
        logic [REM_W-1:0] part;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign part  = {rem_reg[i][REM_W-3:0], x_reg[i][RAD_W-1:RAD_W-2]};
        assign trial = {root_reg[i], 2'b01};
        assign ge    = part >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= {x_reg[i][RAD_W-3:0], 2'b00};
                rem_reg[i+1]  <= ge ? (part - trial) : part;
                root_reg[i+1] <= {root_reg[i][LEN_W-2:0], ge};
                tag_reg[i+1]  <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[LEN_W];
    assign root      = root_reg[LEN_W];
    assign out_tag   = tag_reg[LEN_W];

endmodule

@@ sv/falling_object_length_measure.sv @@
// Falling object length measure, top level.
// Input words carry the transit delay between the two sensors and the bounding
// box extremes of one object; each gives exactly one output word with the
// larger diagonal in mm (truncated, saturating at 65535) and a status code.
// Channels: s_tvalid/s_tready/s_tdata in, m_tvalid/m_tready/m_tdata out, plus a
// write-only register port (cfg_we, cfg_addr, cfg_data) for the two column
// offsets; write it only while no word is in flight.
// Throughput: one word per cycle while the output buffer is not full. The
// pipeline depth is set by the two bit-serial divider pipelines (48 and
// 16 + FRAC_BITS stages) and the 16-stage root pipeline.
// Reset clears the offsets, all valid bits and the output buffer.
// A two-word output buffer sits after the pipeline; the pipeline keeps moving
// and input is still taken while one word waits there, and only when both
// entries are held does the whole pipeline freeze with s_tready low.
// Nothing is lost or repeated during a stall.
// Zero delay gives status 1 and length 0, bottom row above top row gives
// status 2 and length 0.
// depends on flom_pkg, flom_div, flom_isqrt and the assertion macro header
`include "falling_object_length_measure_macros.svh"

module falling_object_length_measure #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config register port
    input  logic                             cfg_we,
    input  logic [flom_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [COORD_BITS-1:0]            cfg_data,
    // input word
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // transit_delay_us, top_row, bottom_row, left_col, right_col, top_left_col,
    // top_right_col, bottom_left_col, bottom_right_col, left_col_last_row,
    // right_col_last_row, zero pad
    input  logic [((flom_pkg::DELAY_W+10*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // output word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // length_mm, status, zero pad
    output logic [flom_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import flom_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int N_W    = C + 1;
    localparam int SQ_W   = (FRAC_BITS < 16) ? FRAC_BITS : 16;
    localparam int V_W    = LEN_W + FRAC_BITS;
    localparam int OP_W   = LEN_W + SQ_W;
    localparam int P1_W   = N_W + K1_BITS;
    localparam int ND_W   = N_W + DELAY_W;
    localparam int NN_W   = 2 * N_W;
    localparam int P2_W   = ND_W + K2_BITS;
    localparam int P3_W   = NN_W + K3_BITS;
    localparam int T2_W   = P2_W - 16;
    localparam int T3_W   = P3_W - 8;
    localparam int PV_W   = V_W + C;
    localparam int SQR_W  = 2 * OP_W;
    localparam int T_W    = RAD_W + 1;
    localparam int WORD_W = LEN_W + STATUS_W;
    localparam int TAG1_W = STATUS_W + N_W + C + N_W + C + ND_W + NN_W;
    localparam int TAG2_W = STATUS_W + 1 + V_W + C + N_W;
    localparam int FLG_W  = $bits(flom_flags_t);

    // ------------------------------------------------------------------
    // config registers
    logic [C-1:0] reo_reg;
    logic [C-1:0] leo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reo_reg <= '0;
            leo_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_RIGHT_EDGE_OFFSET: reo_reg <= cfg_data;
                REG_LEFT_EDGE_OFFSET:  leo_reg <= cfg_data;
                default:               reo_reg <= reo_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance, frozen only when the output buffer is full
    logic [1:0] ocnt_reg;
    logic       adv;
    logic       accept;

    assign adv      = (ocnt_reg != 2'd2);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // ------------------------------------------------------------------
    // stage a: unpack, status, row count and integer extents
    logic [DELAY_W-1:0] f_delay;
    logic [C-1:0]       f_top, f_bot, f_lc, f_rc, f_tl, f_tr, f_bl, f_br, f_llr, f_rlr;

    assign f_delay = s_tdata[DELAY_W-1:0];
    assign f_top   = s_tdata[DELAY_W + 0*C +: C];
    assign f_bot   = s_tdata[DELAY_W + 1*C +: C];
    assign f_lc    = s_tdata[DELAY_W + 2*C +: C];
    assign f_rc    = s_tdata[DELAY_W + 3*C +: C];
    assign f_tl    = s_tdata[DELAY_W + 4*C +: C];
    assign f_tr    = s_tdata[DELAY_W + 5*C +: C];
    assign f_bl    = s_tdata[DELAY_W + 6*C +: C];
    assign f_br    = s_tdata[DELAY_W + 7*C +: C];
    assign f_llr   = s_tdata[DELAY_W + 8*C +: C];
    assign f_rlr   = s_tdata[DELAY_W + 9*C +: C];

    status_t      status_next;
    logic [N_W-1:0] n_next;
    logic [N_W-1:0] sum_b, sum_t, lx_diff;
    logic [N_W-1:0] h_pos, h_neg, h_next;
    logic [C-1:0]   lx_next, dy_next;

    always_comb
    begin
        if (f_delay == '0)
        begin
            status_next = ST_ZERO_DELAY;
        end
        else if (f_bot < f_top)
        begin
            status_next = ST_ROW_ORDER;
        end
        else
        begin
            status_next = ST_OK;
        end
        n_next  = N_W'(f_bot) - N_W'(f_top) + N_W'(1);
        sum_b   = N_W'(f_br) + N_W'(f_bl);
        sum_t   = N_W'(f_tr) + N_W'(f_tl);
        lx_diff = (sum_b >= sum_t) ? (sum_b - sum_t) : (sum_t - sum_b);
        lx_next = lx_diff[C:1];
        h_pos   = N_W'(f_rc) + N_W'(leo_reg) + N_W'(1);
        h_neg   = N_W'(f_lc) + N_W'(reo_reg);
        h_next  = (h_pos >= h_neg) ? (h_pos - h_neg) : (h_neg - h_pos);
        dy_next = (f_rlr >= f_llr) ? (f_rlr - f_llr) : (f_llr - f_rlr);
    end

    logic               sa_valid_reg;
    status_t            sa_status_reg;
    logic [DELAY_W-1:0] sa_delay_reg;
    logic [N_W-1:0]     sa_n_reg, sa_h_reg;
    logic [C-1:0]       sa_lx_reg, sa_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_status_reg <= status_next;
            sa_delay_reg  <= f_delay;
            sa_n_reg      <= n_next;
            sa_h_reg      <= h_next;
            sa_lx_reg     <= lx_next;
            sa_dy_reg     <= dy_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: first products
    logic               sb_valid_reg;
    status_t            sb_status_reg;
    logic [DELAY_W-1:0] sb_delay_reg;
    logic [N_W-1:0]     sb_n_reg, sb_h_reg;
    logic [C-1:0]       sb_lx_reg, sb_dy_reg;
    logic [P1_W-1:0]    sb_p1_reg;
    logic [ND_W-1:0]    sb_nd_reg;
    logic [NN_W-1:0]    sb_nn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_status_reg <= sa_status_reg;
            sb_delay_reg  <= sa_delay_reg;
            sb_n_reg      <= sa_n_reg;
            sb_h_reg      <= sa_h_reg;
            sb_lx_reg     <= sa_lx_reg;
            sb_dy_reg     <= sa_dy_reg;
            sb_p1_reg     <= P1_W'(sa_n_reg) * P1_W'(K1_Q32);
            sb_nd_reg     <= ND_W'(sa_n_reg) * ND_W'(sa_delay_reg);
            sb_nn_reg     <= NN_W'(sa_n_reg) * NN_W'(sa_n_reg);
        end
    end

    // ------------------------------------------------------------------
    // divider one: n*K1 / delay
    logic              d1_valid, d1_ovf;
    logic [VQ_INT_POS-1:0] d1_quo;
    logic [TAG1_W-1:0] d1_tag;

    flom_div #(
        .NUM_W (P1_W),
        .DEN_W (DELAY_W),
        .QUO_W (VQ_INT_POS),
        .TAG_W (TAG1_W)
    ) u_div_vert (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sb_valid_reg),
        .num       (sb_p1_reg),
        .den       (sb_delay_reg),
        .in_tag    ({sb_status_reg, sb_n_reg, sb_lx_reg, sb_h_reg, sb_dy_reg,
                     sb_nd_reg, sb_nn_reg}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .ovf       (d1_ovf),
        .out_tag   (d1_tag)
    );

    logic [STATUS_W-1:0] u1_status;
    logic [N_W-1:0]      u1_n, u1_h;
    logic [C-1:0]        u1_lx, u1_dy;
    logic [ND_W-1:0]     u1_nd;
    logic [NN_W-1:0]     u1_nn;

    assign {u1_status, u1_n, u1_lx, u1_h, u1_dy, u1_nd, u1_nn} = d1_tag;

    // ------------------------------------------------------------------
    // stage c: velocity and gravity terms
    logic [P2_W-1:0] p2_next;
    logic [P3_W-1:0] p3_next;

    assign p2_next = P2_W'(u1_nd) * P2_W'(K2_Q48);
    assign p3_next = P3_W'(u1_nn) * P3_W'(K3_Q40);

    logic                  sc_valid_reg;
    status_t               sc_status_reg;
    logic [N_W-1:0]        sc_n_reg, sc_h_reg;
    logic [C-1:0]          sc_lx_reg, sc_dy_reg;
    logic [VQ_INT_POS-1:0] sc_q1_reg;
    logic                  sc_ovf_reg;
    logic [T2_W-1:0]       sc_t2_reg;
    logic [T3_W-1:0]       sc_t3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sc_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_status_reg <= status_t'(u1_status);
            sc_n_reg      <= u1_n;
            sc_h_reg      <= u1_h;
            sc_lx_reg     <= u1_lx;
            sc_dy_reg     <= u1_dy;
            sc_q1_reg     <= d1_quo;
            sc_ovf_reg    <= d1_ovf;
            sc_t2_reg     <= p2_next[P2_W-1:16];
            sc_t3_reg     <= p3_next[P3_W-1:8];
        end
    end

    // ------------------------------------------------------------------
    // stage d: vertical extent, saturation
    logic [VQ_W-1:0] vq_next;
    logic            h_big;
    logic            sat_d_next;

    assign vq_next    = VQ_W'(sc_q1_reg) + VQ_W'(sc_t2_reg) + VQ_W'(sc_t3_reg);
    assign h_big      = (17'(sc_h_reg) >= 17'h10000);
    assign sat_d_next = sc_ovf_reg || (vq_next[VQ_W-1:VQ_INT_POS] != '0) || h_big;

    logic           sd_valid_reg;
    status_t        sd_status_reg;
    logic           sd_sat_reg;
    logic [V_W-1:0] sd_v_reg;
    logic [N_W-1:0] sd_n_reg, sd_h_reg;
    logic [C-1:0]   sd_lx_reg, sd_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sd_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_status_reg <= sc_status_reg;
            sd_sat_reg    <= sat_d_next;
            sd_v_reg      <= vq_next[VQ_INT_POS-V_W +: V_W];
            sd_n_reg      <= sc_n_reg;
            sd_h_reg      <= sc_h_reg;
            sd_lx_reg     <= sc_lx_reg;
            sd_dy_reg     <= sc_dy_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage e: lean product v * dy
    logic            se_valid_reg;
    status_t         se_status_reg;
    logic            se_sat_reg;
    logic [V_W-1:0]  se_v_reg;
    logic [N_W-1:0]  se_n_reg, se_h_reg;
    logic [C-1:0]    se_lx_reg;
    logic [PV_W-1:0] se_pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            se_valid_reg <= sd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            se_status_reg <= sd_status_reg;
            se_sat_reg    <= sd_sat_reg;
            se_v_reg      <= sd_v_reg;
            se_n_reg      <= sd_n_reg;
            se_h_reg      <= sd_h_reg;
            se_lx_reg     <= sd_lx_reg;
            se_pv_reg     <= PV_W'(sd_v_reg) * PV_W'(sd_dy_reg);
        end
    end

    // ------------------------------------------------------------------
    // divider two: v*dy / n
    logic              d2_valid, d2_ovf;
    logic [V_W-1:0]    d2_quo;
    logic [TAG2_W-1:0] d2_tag;

    flom_div #(
        .NUM_W (PV_W),
        .DEN_W (N_W),
        .QUO_W (V_W),
        .TAG_W (TAG2_W)
    ) u_div_lean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (se_valid_reg),
        .num       (se_pv_reg),
        .den       (se_n_reg),
        .in_tag    ({se_status_reg, se_sat_reg, se_v_reg, se_lx_reg, se_h_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .ovf       (d2_ovf),
        .out_tag   (d2_tag)
    );

    logic [STATUS_W-1:0] u2_status;
    logic                u2_sat;
    logic [V_W-1:0]      u2_v;
    logic [C-1:0]        u2_lx;
    logic [N_W-1:0]      u2_h;

    assign {u2_status, u2_sat, u2_v, u2_lx, u2_h} = d2_tag;

    // ------------------------------------------------------------------
    // stage f: operands in Q.SQ_W and their squares
    logic [OP_W-1:0] av, bv, ah, bh;
    logic [15:0]     h16;

    assign h16 = 16'(u2_h);
    assign av  = u2_v[FRAC_BITS-SQ_W +: OP_W];
    assign bv  = OP_W'({u2_lx, {SQ_W{1'b0}}});
    assign ah  = {h16, {SQ_W{1'b0}}};
    assign bh  = d2_quo[FRAC_BITS-SQ_W +: OP_W];

    logic             sf_valid_reg;
    flom_flags_t      sf_flags_reg;
    logic [SQR_W-1:0] sf_av2_reg, sf_bv2_reg, sf_ah2_reg, sf_bh2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sf_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sf_flags_reg.status <= status_t'(u2_status);
            sf_flags_reg.sat    <= u2_sat || d2_ovf;
            sf_av2_reg          <= SQR_W'(av) * SQR_W'(av);
            sf_bv2_reg          <= SQR_W'(bv) * SQR_W'(bv);
            sf_ah2_reg          <= SQR_W'(ah) * SQR_W'(ah);
            sf_bh2_reg          <= SQR_W'(bh) * SQR_W'(bh);
        end
    end

    // ------------------------------------------------------------------
    // stage g: sums of squares scaled back to integer mm^2
    logic [SQR_W:0] sum_v, sum_h;

    assign sum_v = (SQR_W + 1)'(sf_av2_reg) + (SQR_W + 1)'(sf_bv2_reg);
    assign sum_h = (SQR_W + 1)'(sf_ah2_reg) + (SQR_W + 1)'(sf_bh2_reg);

    logic           sg_valid_reg;
    flom_flags_t    sg_flags_reg;
    logic [T_W-1:0] sg_tv_reg, sg_th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sg_valid_reg <= sf_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sg_flags_reg <= sf_flags_reg;
            sg_tv_reg    <= sum_v[2*SQ_W +: T_W];
            sg_th_reg    <= sum_h[2*SQ_W +: T_W];
        end
    end

    // ------------------------------------------------------------------
    // stage h: root is monotonic, so take the larger radicand once
    flom_flags_t      flags_h_next;
    logic [RAD_W-1:0] rad_next;

    always_comb
    begin
        flags_h_next     = sg_flags_reg;
        flags_h_next.sat = sg_flags_reg.sat || sg_tv_reg[RAD_W] || sg_th_reg[RAD_W];
        rad_next         = (sg_tv_reg[RAD_W-1:0] > sg_th_reg[RAD_W-1:0]) ?
                           sg_tv_reg[RAD_W-1:0] : sg_th_reg[RAD_W-1:0];
    end

    logic             sh_valid_reg;
    flom_flags_t      sh_flags_reg;
    logic [RAD_W-1:0] sh_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sh_valid_reg <= sg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_flags_reg <= flags_h_next;
            sh_rad_reg   <= rad_next;
        end
    end

    // ------------------------------------------------------------------
    // square root
    logic             rt_valid;
    logic [LEN_W-1:0] rt_root;
    logic [FLG_W-1:0] rt_tag;
    flom_flags_t      rt_flags;

    flom_isqrt #(
        .TAG_W (FLG_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sh_valid_reg),
        .rad       (sh_rad_reg),
        .in_tag    (sh_flags_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .out_tag   (rt_tag)
    );

    assign rt_flags = flom_flags_t'(rt_tag);

    // final word: errors win over saturation
    logic [LEN_W-1:0]  len_next;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        if (rt_flags.status != ST_OK)
        begin
            len_next = '0;
        end
        else if (rt_flags.sat)
        begin
            len_next = '1;
        end
        else
        begin
            len_next = rt_root;
        end
        word_next = {rt_flags.status, len_next};
    end

    // ------------------------------------------------------------------
    // two-entry output buffer
    logic [WORD_W-1:0] head_reg, tail_reg;
    logic              push, pop;

    assign push = adv && rt_valid;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= 2'd0;
        end
        else
        begin
            case ({push, pop})
                2'b10:   ocnt_reg <= ocnt_reg + 2'd1;
                2'b01:   ocnt_reg <= ocnt_reg - 2'd1;
                default: ocnt_reg <= ocnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (ocnt_reg == 2'd0)
                begin
                    head_reg <= word_next;
                end
                else
                begin
                    tail_reg <= word_next;
                end
            end
            2'b01:
            begin
                head_reg <= tail_reg;
            end
            2'b11:
            begin
                head_reg <= word_next;
            end
            default:
            begin
                head_reg <= head_reg;
            end
        endcase
    end

    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tdata  = OUT_TDATA_W'(head_reg);

    // ------------------------------------------------------------------
    // checks
    `FLOM_ASSERT_IMP(a_err_zero_len,
        m_tvalid && (head_reg[WORD_W-1:LEN_W] != ST_OK),
        head_reg[LEN_W-1:0] == '0,
        "error word with nonzero length")
    `FLOM_ASSERT_NXT(a_full_holds,
        (ocnt_reg == 2'd2) && !m_tready,
        ocnt_reg == 2'd2,
        "full output buffer lost a word")
    `FLOM_ASSERT_NXT(a_pop_count,
        pop && !push,
        ocnt_reg == ($past(ocnt_reg) - 2'd1),
        "output buffer count wrong after pop")

endmodule

@@ sim/tb_falling_object_length_measure.sv @@
// self-checking testbench for falling_object_length_measure
// directed table plus random words, checked against an in-bench length predictor
// depends on flom_pkg and the falling_object_length_measure top level
`timescale 1ns / 1ps

module tb_falling_object_length_measure;
    import flom_pkg::*;

    localparam int CB     = 12;
    localparam int IN_W   = ((DELAY_W + 10 * CB + 7) / 8) * 8;
    localparam int DRAIN  = 150;

    typedef struct {
        logic [15:0]   delay;
        logic [CB-1:0] top_row;
        logic [CB-1:0] bot_row;
        logic [CB-1:0] lc;
        logic [CB-1:0] rc;
        logic [CB-1:0] tl;
        logic [CB-1:0] tr;
        logic [CB-1:0] bl;
        logic [CB-1:0] br;
        logic [CB-1:0] llr;
        logic [CB-1:0] rlr;
    } object_t;

    typedef struct {
        object_t     obj;
        bit          typed;
        logic [15:0] len;
        status_t     st;
    } table_row_t;

    typedef struct {
        logic [15:0] len;
        status_t     st;
    } length_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CB-1:0]     cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    // transit_delay_us, top_row, bottom_row, left_col, right_col, top_left_col,
    // top_right_col, bottom_left_col, bottom_right_col, left_col_last_row,
    // right_col_last_row
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // length_mm, status, zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [CB-1:0]     right_ofs;
    logic [CB-1:0]     left_ofs;
    length_t           pending_lengths[$];
    table_row_t        dir_table[$];
    bit                failed;
    bit                no_gaps;

    falling_object_length_measure u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // truncated root of a^2+b^2, both in Q16, saturating
    function automatic bit [63:0] diagonal_mm(input bit [63:0] a, input bit [63:0] b);
        bit [64:0] sum;
        bit [63:0] x;
        bit [63:0] r;
        bit [63:0] t;
        if (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000)
            return 64'd65535;
        sum = {1'b0, a * a} + {1'b0, b * b};
        if (sum[64])
            return 64'd65535;
        x = sum[63:0] >> 32;
        r = 0;
        for (int i = 15; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic bit [63:0] abs_diff(input bit [63:0] a, input bit [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // predicted length and status of one object
    function automatic length_t predict_length(input object_t o, input logic [CB-1:0] ro,
                                               input logic [CB-1:0] lo);
        length_t   res;
        bit [63:0] d, n, vq, v, lx, h, dy, ly, dv, dh;
        d = 64'(o.delay);
        res.len = 0;
        res.st = ST_OK;
        if (d == 0)
        begin
            res.st = ST_ZERO_DELAY;
            return res;
        end
        if (o.bot_row < o.top_row)
        begin
            res.st = ST_ROW_ORDER;
            return res;
        end
        n = 64'(o.bot_row) - 64'(o.top_row) + 1;
        vq = (n * K1_Q32) / d + ((n * d * K2_Q48) >> 16) + ((n * n * K3_Q40) >> 8);
        if (vq >= (64'd65536 << 32))
        begin
            res.len = 16'hFFFF;
            return res;
        end
        v = vq >> 16;
        lx = abs_diff(64'(o.br) + 64'(o.bl), 64'(o.tr) + 64'(o.tl)) >> 1;
        h = abs_diff(1 + 64'(o.rc) + 64'(lo), 64'(o.lc) + 64'(ro));
        dy = abs_diff(64'(o.rlr), 64'(o.llr));
        ly = (v * dy) / n;
        dv = diagonal_mm(v, lx << 16);
        dh = diagonal_mm(h << 16, ly);
        res.len = (dv > dh) ? dv[15:0] : dh[15:0];
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic object_t random_object();
        object_t o;
        int      kind;
        int      span;
        kind = $urandom_range(0, 9);
        o.delay = 16'($urandom);
        o.top_row = CB'($urandom);
        o.bot_row = CB'($urandom);
        o.lc = CB'($urandom);
        o.rc = CB'($urandom);
        o.tl = CB'($urandom);
        o.tr = CB'($urandom);
        o.bl = CB'($urandom);
        o.br = CB'($urandom);
        o.llr = CB'($urandom);
        o.rlr = CB'($urandom);
        if (kind < 6)
        begin
            // plausible object: mostly short row span, delay large enough to stay in range
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 200);
            o.top_row = CB'($urandom_range(0, 4095 - span));
            o.bot_row = CB'(o.top_row + span);
            o.delay = 16'($urandom_range(span * 70 / 1000 + 1, 65535));
        end
        else if (kind == 8)
            o.delay = 0;
        else if (kind == 9)
        begin
            o.top_row = CB'($urandom_range(1, 4095));
            o.bot_row = CB'($urandom_range(0, o.top_row - 1));
        end
        return o;
    endfunction

    task automatic add_row(input logic [15:0] d, input logic [CB-1:0] t, input logic [CB-1:0] b,
                           input logic [CB-1:0] lc, input logic [CB-1:0] rc,
                           input logic [CB-1:0] tl, input logic [CB-1:0] tr,
                           input logic [CB-1:0] bl, input logic [CB-1:0] br,
                           input logic [CB-1:0] llr, input logic [CB-1:0] rlr,
                           input bit typed, input logic [15:0] len, input status_t st);
        table_row_t row;
        row.obj = '{d, t, b, lc, rc, tl, tr, bl, br, llr, rlr};
        row.typed = typed;
        row.len = len;
        row.st = st;
        dir_table.push_back(row);
    endtask

    // one write, then idle with the enable low before returning
    task automatic write_reg(input cfg_reg_t idx, input logic [CB-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RIGHT_EDGE_OFFSET)
            right_ofs = val;
        else
            left_ofs = val;
        @(posedge clk);
    endtask

    // send one word, queue its expected result on acceptance
    task automatic send_object(input object_t o, input bit typed, input length_t typed_res);
        int      gap;
        bit      rdy;
        length_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {o.rlr, o.llr, o.br, o.bl, o.tr, o.tl, o.rc, o.lc,
                    o.bot_row, o.top_row, o.delay};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        res = typed ? typed_res : predict_length(o, right_ofs, left_ofs);
        pending_lengths.push_back(res);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // receiver back-pressure
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // output check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        length_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lengths.size() == 0)
            begin
                $display("%0t: unexpected word, actual len %0d status %0d",
                         $time, m_tdata[15:0], m_tdata[17:16]);
                failed = 1'b1;
            end
            else
            begin
                exp_res = pending_lengths.pop_front();
                if (m_tdata[15:0] !== exp_res.len)
                begin
                    $display("%0t: length_mm expected %0d actual %0d",
                             $time, exp_res.len, m_tdata[15:0]);
                    failed = 1'b1;
                end
                if (m_tdata[17:16] !== exp_res.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.st, m_tdata[17:16]);
                    failed = 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        length_t none;
        length_t typed_res;
        logic [CB-1:0] ofs_r[4];
        logic [CB-1:0] ofs_l[4];
        no_gaps = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        right_ofs = '0;
        left_ofs = '0;
        none.len = 0;
        none.st = ST_OK;

        // zero delay, inverted rows, saturation, field extremes
        add_row(16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'd0, ST_ZERO_DELAY);
        add_row(16'd0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                1, 16'd0, ST_ZERO_DELAY);
        add_row(16'd1000, 10, 9, 5, 50, 5, 50, 5, 50, 9, 9, 1, 16'd0, ST_ROW_ORDER);
        add_row(16'hFFFF, 4095, 0, 0, 4095, 0, 4095, 0, 4095, 0, 4095, 1, 16'd0, ST_ROW_ORDER);
        add_row(16'd1, 0, 4095, 0, 4095, 0, 4095, 0, 4095, 0, 4095, 1, 16'hFFFF, ST_OK);
        add_row(16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(16'hFFFF, 0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 0, 0, ST_OK);
        add_row(16'd5000, 100, 200, 50, 300, 60, 290, 70, 280, 190, 180, 0, 0, ST_OK);
        add_row(16'd3000, 500, 520, 4095, 0, 2000, 2010, 2000, 2010, 510, 515, 0, 0, ST_OK);
        add_row(16'd8000, 0, 40, 0, 4095, 0, 0, 4095, 4095, 0, 40, 0, 0, ST_OK);
        add_row(16'd20000, 7, 7, 100, 101, 100, 101, 100, 101, 0, 4095, 0, 0, ST_OK);
        add_row(16'd40000, 4095, 4095, 0, 4095, 4095, 0, 0, 4095, 4095, 0, 0, 0, ST_OK);
        add_row(16'd2, 1000, 1000, 1, 2, 1, 2, 1, 2, 1000, 1000, 0, 0, ST_OK);
        add_row(16'd600, 0, 10, 4095, 4095, 0, 4095, 4095, 0, 10, 0, 0, 0, ST_OK);

        ofs_r = '{12'd0, 12'd4095, 12'd0, 12'd0};
        ofs_l = '{12'd0, 12'd4095, 12'd4095, 12'd0};
        ofs_r[3] = CB'($urandom);
        ofs_l[3] = CB'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one pass per offset setting, drained before each register write
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_RIGHT_EDGE_OFFSET, ofs_r[ph]);
            write_reg(REG_LEFT_EDGE_OFFSET, ofs_l[ph]);
            no_gaps = (ph == 2);
            if (ph == 0)
                foreach (dir_table[i])
                begin
                    typed_res.len = dir_table[i].len;
                    typed_res.st = dir_table[i].st;
                    send_object(dir_table[i].obj, dir_table[i].typed, typed_res);
                end
            for (int i = 0; i < 100; i++)
                send_object(random_object(), 1'b0, none);
            wait_idle();
        end

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
